// ===== hdl/shx_pkg.sv =====
// ============================================================================
// shx_pkg: shared types and constants of the SHA-256 hex digest block
// Round constants, initial hash values, helper functions and the queue entry.
// ============================================================================
package shx_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned CountWidth = 61;

   localparam logic CmdAppend = 1'b0;
   localparam logic CmdFinish = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
   } item_type;

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] InitH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   // map one nibble to its lower-case ASCII digit
   function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
      logic [6:0] r;
      if (nib < 4'd10) begin
         r = 7'h30 + {3'b000, nib};
      end else begin
         r = 7'h57 + {3'b000, nib};
      end
      hex_ascii = r;
   endfunction

endpackage

// ===== hdl/shx_front.sv =====
// ============================================================================
// shx_front: input queue
// Hold accepted request beats in a short queue ahead of the hash engine.
// ============================================================================
module shx_front
   import shx_pkg::*;
#(
   parameter int unsigned DEPTH = QueueDepth
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     nonempty
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type        mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]     cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign nonempty = (cnt_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && nonempty;
   assign pop_item = mem_ff[rd_ff];

   // advance pointers and count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("queue count overflow");
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      full && !pop |=> $stable(cnt_ff)) else $error("count moved while full");
   a_empty_nopop: assert property (@(posedge clock) disable iff (reset)
      !nonempty && !push |=> !nonempty) else $error("queue filled from nowhere");

endmodule

// ===== hdl/shx_engine.sv =====
// ============================================================================
// shx_engine: SHA-256 byte collector, compressor and hex emitter
// Collect bytes into a block, run 64 rounds per block, pad, and emit hex.
// ============================================================================
module shx_engine
   import shx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_take,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [6:0] rsp_hex_char,
   output logic       rsp_last_char
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_ROUND, ST_ADD, ST_PAD, ST_EMIT
   } state_type;

   state_type        state_ff;
   logic [31:0]      buf_ff [16];  // block buffer, four bytes per word, big-endian
   logic [5:0]       idx_ff;
   logic [CountWidth-1:0] count_ff;
   logic [31:0]      h_ff [8];
   logic [31:0]      v_ff [8];
   logic [31:0]      w_ff [16];
   logic [5:0]       t_ff;
   logic [3:0]       ld_ff;
   logic             fin_ff;     // compressing a padding block
   logic             second_ff;  // one more padding block follows
   logic [5:0]       pad_ff;
   logic [5:0]       ch_ff;
   logic             out_v_ff;
   logic [6:0]       out_c_ff;
   logic             out_l_ff;

   logic [31:0] x15, x2, s0, s1, wnew, wcur, big1, chf, t1, big0, maj;
   logic [63:0] bits;
   logic [31:0] hword;
   logic [3:0]  nib;
   logic        slot_free;
   logic        emit_fire;

   assign bits      = {count_ff, 3'b000};
   assign item_take = (state_ff == ST_IDLE) && item_valid;
   assign rsp_empty     = !out_v_ff;
   assign rsp_hex_char  = out_c_ff;
   assign rsp_last_char = out_l_ff;
   assign slot_free = !out_v_ff || rsp_pop;
   assign emit_fire = (state_ff == ST_EMIT) && slot_free;

   // schedule expansion and round function
   always_comb begin
      x15  = w_ff[1];
      x2   = w_ff[14];
      s0   = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
      s1   = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
      wnew = w_ff[0] + s0 + w_ff[9] + s1;
      wcur = w_ff[0];
      big1 = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      chf  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1   = v_ff[7] + big1 + chf + RoundK[t_ff] + wcur;
      big0 = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      maj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      hword = h_ff[ch_ff[5:3]];
      nib   = hword[5'd28 - {ch_ff[2:0], 2'b00} +: 4];
   end

   // hold the output beat until it is popped
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (emit_fire) begin
         out_v_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_v_ff <= 1'b0;
      end
   end

   // sequence collection, rounds, padding and emission
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         count_ff <= '0;
         fin_ff   <= 1'b0;
         second_ff <= 1'b0;
         out_c_ff <= '0;
         out_l_ff <= 1'b0;
         for (int i = 0; i < 8; i++) h_ff[i] <= InitH[i];
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (item_valid) begin
                  if (item.cmd == CmdAppend) begin
                     buf_ff[idx_ff[5:2]][8*(3-idx_ff[1:0]) +: 8] <= item.data_byte;
                     idx_ff   <= idx_ff + 1'b1;
                     count_ff <= count_ff + 1'b1;
                     fin_ff   <= 1'b0;
                     ld_ff    <= '0;
                     if (idx_ff == 6'd63) state_ff <= ST_LOAD;
                  end else begin
                     buf_ff[idx_ff[5:2]][8*(3-idx_ff[1:0]) +: 8] <= 8'h80;
                     pad_ff    <= idx_ff + 1'b1;
                     second_ff <= (idx_ff >= 6'd56);
                     state_ff  <= (idx_ff == 6'd63) ? ST_LOAD : ST_PAD;
                     fin_ff    <= 1'b1;
                     ld_ff     <= '0;
                  end
               end
            end
            ST_PAD: begin
               // zero one byte a cycle, then the length field
               if (!second_ff && pad_ff >= 6'd56) begin
                  buf_ff[pad_ff[5:2]][8*(3-pad_ff[1:0]) +: 8] <= bits[8*(63-pad_ff) +: 8];
               end else begin
                  buf_ff[pad_ff[5:2]][8*(3-pad_ff[1:0]) +: 8] <= 8'h00;
               end
               pad_ff <= pad_ff + 1'b1;
               if (pad_ff == 6'd63) begin
                  state_ff <= ST_LOAD;
                  ld_ff    <= '0;
               end
            end
            ST_LOAD: begin
               w_ff[ld_ff] <= buf_ff[ld_ff];
               ld_ff <= ld_ff + 1'b1;
               if (ld_ff == 4'd15) begin
                  for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
                  t_ff     <= '0;
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= wnew;
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + big0 + maj;
               t_ff <= t_ff + 1'b1;
               if (t_ff == 6'd63) state_ff <= ST_ADD;
            end
            ST_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               if (!fin_ff) begin
                  state_ff <= ST_IDLE;
               end else if (second_ff) begin
                  second_ff <= 1'b0;
                  pad_ff    <= '0;
                  state_ff  <= ST_PAD;
               end else begin
                  ch_ff    <= '0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (slot_free) begin
                  out_c_ff <= hex_ascii(nib);
                  out_l_ff <= (ch_ff == 6'd63);
                  ch_ff    <= ch_ff + 1'b1;
                  if (ch_ff == 6'd63) begin
                     for (int i = 0; i < 8; i++) h_ff[i] <= InitH[i];
                     count_ff <= '0;
                     idx_ff   <= '0;
                     fin_ff   <= 1'b0;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      item_take |-> state_ff == ST_IDLE) else $error("item taken while busy");
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_l_ff && rsp_pop |=> !out_v_ff || !out_l_ff)
      else $error("last char not at end");
   a_round_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND && t_ff == 6'd63 |=> state_ff == ST_ADD)
      else $error("round count slip");

endmodule

// ===== hdl/sha256_hex_digest.sv =====
// ============================================================================
// sha256_hex_digest: SHA-256 digest of a byte stream, emitted as hex text
// Queue-style request and response ports; 64 hex characters per message.
// ============================================================================
// Each append beat is written into the block buffer, and every 64th byte
// starts the schedule load, the rounds (one shared round unit, one round per
// cycle) and the add into the hash state. A finish beat pads the remaining
// buffer one byte per cycle, compresses one or two blocks, then emits one
// character per cycle as the response side pops. A request queue, four
// entries deep by default, takes beats while the engine is compressing.
module sha256_hex_digest
   import shx_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic       req_cmd,
   input  logic [7:0] req_data_byte,
   output logic       empty,
   input  logic       pop,
   output logic [6:0] rsp_hex_char,
   output logic       rsp_last_char
);

   item_type in_item, q_item;
   logic     q_nonempty, q_take;

   assign in_item.cmd       = req_cmd;
   assign in_item.data_byte = req_data_byte;

   shx_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock, .reset,
      .push, .push_item(in_item), .full,
      .pop(q_take), .pop_item(q_item), .nonempty(q_nonempty)
   );

   shx_engine u_engine (
      .clock, .reset,
      .item_valid(q_nonempty), .item(q_item), .item_take(q_take),
      .rsp_empty(empty), .rsp_pop(pop),
      .rsp_hex_char, .rsp_last_char
   );

endmodule
